// ===== design/mrsp_pkg.sv =====
package mrsp_pkg;

    // one RGB pixel as it moves through the block
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pix_t;

    // control that travels with a pixel into the sepia pipeline
    typedef struct packed {
        logic valid;
        logic last;
        logic sepia;
    } pix_ctl_t;

    // configuration register indexes
    localparam logic [1:0] REG_ROW_WIDTH     = 2'd0;
    localparam logic [1:0] REG_MIRROR_ENABLE = 2'd1;
    localparam logic [1:0] REG_SEPIA_ENABLE  = 2'd2;

    localparam logic [6:0] ROW_WIDTH_RESET = 7'd64;

    // sepia matrix, Q0.16, rounded to nearest
    localparam logic [15:0] C_RR = 16'd25756;
    localparam logic [15:0] C_RG = 16'd50397;
    localparam logic [15:0] C_RB = 16'd12386;
    localparam logic [15:0] C_GR = 16'd22872;
    localparam logic [15:0] C_GG = 16'd44958;
    localparam logic [15:0] C_GB = 16'd11010;
    localparam logic [15:0] C_BR = 16'd17826;
    localparam logic [15:0] C_BG = 16'd34996;
    localparam logic [15:0] C_BB = 16'd8585;

endpackage

// ===== design/mrsp_row_store.sv =====
module mrsp_row_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  mrsp_pkg::pix_t       wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output mrsp_pkg::pix_t       rd_data
);
    import mrsp_pkg::*;

    pix_t mem [DEPTH];
    pix_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/mrsp_sepia.sv =====
module mrsp_sepia (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mrsp_pkg::pix_ctl_t   in_ctl,
    input  mrsp_pkg::pix_t       in_pix,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mrsp_pkg::pix_t       out_pix,
    output logic                 out_last
);
    import mrsp_pkg::*;

    // stage 1: products
    logic        v1_reg, v1_next;
    logic        last1_reg;
    logic        sep1_reg;
    pix_t        pix1_reg;
    logic [23:0] prod_reg [9];

    // stage 2: output word
    logic        v2_reg, v2_next;
    logic        last2_reg;
    pix_t        pix2_reg;

    logic        ready1;
    logic        ready2;
    logic        load1;
    logic        load2;
    logic [25:0] sum_r;
    logic [25:0] sum_g;
    logic [25:0] sum_b;
    pix_t        sep_pix;

    function automatic logic [7:0] sat8(input logic [25:0] s);
        logic [9:0] v;
        v = s[25:16];
        return (|v[9:8]) ? 8'hFF : v[7:0];
    endfunction

    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;
    assign load1    = in_ctl.valid && ready1;
    assign load2    = v1_reg && ready2;

    always_comb begin
        v1_next = v1_reg;
        if (ready1) begin
            v1_next = in_ctl.valid;
        end
        v2_next = v2_reg;
        if (ready2) begin
            v2_next = v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            last1_reg   <= in_ctl.last;
            sep1_reg    <= in_ctl.sepia;
            pix1_reg    <= in_pix;
            prod_reg[0] <= 24'(C_RR) * 24'(in_pix.red);
            prod_reg[1] <= 24'(C_RG) * 24'(in_pix.green);
            prod_reg[2] <= 24'(C_RB) * 24'(in_pix.blue);
            prod_reg[3] <= 24'(C_GR) * 24'(in_pix.red);
            prod_reg[4] <= 24'(C_GG) * 24'(in_pix.green);
            prod_reg[5] <= 24'(C_GB) * 24'(in_pix.blue);
            prod_reg[6] <= 24'(C_BR) * 24'(in_pix.red);
            prod_reg[7] <= 24'(C_BG) * 24'(in_pix.green);
            prod_reg[8] <= 24'(C_BB) * 24'(in_pix.blue);
        end
    end

    always_comb begin
        sum_r = {2'b00, prod_reg[0]} + {2'b00, prod_reg[1]} + {2'b00, prod_reg[2]};
        sum_g = {2'b00, prod_reg[3]} + {2'b00, prod_reg[4]} + {2'b00, prod_reg[5]};
        sum_b = {2'b00, prod_reg[6]} + {2'b00, prod_reg[7]} + {2'b00, prod_reg[8]};
        sep_pix.red   = sat8(sum_r);
        sep_pix.green = sat8(sum_g);
        sep_pix.blue  = sat8(sum_b);
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            last2_reg <= last1_reg;
            pix2_reg  <= sep1_reg ? sep_pix : pix1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_pix   = pix2_reg;
    assign out_last  = last2_reg;

endmodule

// ===== design/mirror_row_sepia_pixel_stream_unit.sv =====
// Plain mode: an accepted word is held in pix_reg, handed on in ST_PUSH, then
// passes the sepia product stage and output register. Mirror mode: row pixels
// are stored at 1 word per cycle; the completing pixel starts a burst read of
// the store, each output word a read (ST_READ), then handoff to sepia (ST_PUSH).
// Plain mode takes no new word until the last is handed on. Reset (aresetn, sync,
// active low) clears control, column count and config; the store is not cleared.
module mirror_row_sepia_pixel_stream_unit #(
    parameter int MAX_ROW_WIDTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data,
    // input pixel channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_red_in,
    input  logic [7:0] s_green_in,
    input  logic [7:0] s_blue_in,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red_out,
    output logic [7:0] m_green_out,
    output logic [7:0] m_blue_out,
    output logic       m_row_last
);
    import mrsp_pkg::*;

    localparam int AW = $clog2(MAX_ROW_WIDTH);
    // compare width: holds the 7-bit register and MAX_ROW_WIDTH
    localparam int CW = (AW + 1 > 7) ? AW + 1 : 7;
    localparam logic [CW-1:0] MAX_W = CW'(MAX_ROW_WIDTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // take input words
        ST_READ = 3'b010,   // issue row store read
        ST_PUSH = 3'b100    // hand pixel to sepia pipeline
    } state_t;

    state_t        state_reg, state_next;
    logic [6:0]    row_width_reg;
    logic          mirror_reg;
    logic          sepia_reg;
    logic [AW-1:0] col_reg, col_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic          src_mem_reg, src_mem_next;
    logic          last_reg, last_next;
    pix_t          pix_reg;

    logic          s_accept;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] col_plus;
    logic          row_done;
    pix_t          in_pix;
    pix_t          rd_pix;
    pix_t          push_pix;
    pix_ctl_t      push_ctl;
    logic          pipe_ready;
    logic          rd_en;
    pix_t          out_pix;

    assign in_pix   = '{red: s_red_in, green: s_green_in, blue: s_blue_in};
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // config registers; out-of-range index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
            mirror_reg    <= 1'b0;
            sepia_reg     <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ROW_WIDTH:     row_width_reg <= cfg_data;
                REG_MIRROR_ENABLE: mirror_reg    <= cfg_data[0];
                REG_SEPIA_ENABLE:  sepia_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective width: zero acts as one, clamp at the store depth
    always_comb begin
        if (row_width_reg == 7'd0) begin
            w_eff = CW'(1);
        end else if (CW'(row_width_reg) > MAX_W) begin
            w_eff = MAX_W;
        end else begin
            w_eff = CW'(row_width_reg);
        end
    end

    // column count never reaches the depth, so it addresses the store directly
    assign col_plus = CW'(col_reg) + CW'(1);
    assign row_done = (col_plus >= w_eff);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        rd_idx_next  = rd_idx_reg;
        src_mem_next = src_mem_reg;
        last_next    = last_reg;
        rd_en        = 1'b0;
        push_ctl     = '{valid: 1'b0, last: 1'b0, sepia: sepia_reg};
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    col_next    = row_done ? '0 : AW'(col_plus);
                    rd_idx_next = col_reg;
                    last_next   = row_done;
                    if (!mirror_reg) begin
                        src_mem_next = 1'b0;
                        state_next   = ST_PUSH;
                    end else if (row_done) begin
                        // burst the stored row out, last column first
                        src_mem_next = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ: begin
                rd_en      = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                push_ctl.valid = 1'b1;
                push_ctl.last  = src_mem_reg ? (rd_idx_reg == '0) : last_reg;
                if (pipe_ready) begin
                    if (!src_mem_reg || rd_idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg - AW'(1);
                        state_next  = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            col_reg     <= '0;
            rd_idx_reg  <= '0;
            src_mem_reg <= 1'b0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            rd_idx_reg  <= rd_idx_next;
            src_mem_reg <= src_mem_next;
            last_reg    <= last_next;
        end
    end

    // hold the accepted word for the plain path
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pix_reg <= in_pix;
        end
    end

    // every accepted word is stored, in both modes
    mrsp_row_store #(
        .DEPTH (MAX_ROW_WIDTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (s_accept),
        .wr_addr (col_reg),
        .wr_data (in_pix),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_pix)
    );

    assign push_pix = src_mem_reg ? rd_pix : pix_reg;

    // sepia matrix and output register
    mrsp_sepia u_sepia (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (push_ctl),
        .in_pix    (push_pix),
        .in_ready  (pipe_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pix   (out_pix),
        .out_last  (m_row_last)
    );

    assign m_red_out   = out_pix.red;
    assign m_green_out = out_pix.green;
    assign m_blue_out  = out_pix.blue;

endmodule
